@@ design/hid_report_descriptor_parser_macros.svh @@
// Assertion macros for the HID report descriptor parser.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) cond) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/hrdp_pkg.sv @@
package hrdp_pkg;

  typedef enum logic [2:0] {
    S_IN,
    S_EXEC,
    S_POP,
    S_OFF,
    S_UREAD,
    S_EMIT,
    S_OWR,
    S_DONE
  } state_t;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [3:0] TAG_PAGE   = 4'd0;
  localparam logic [3:0] TAG_LMIN   = 4'd1;
  localparam logic [3:0] TAG_LMAX   = 4'd2;
  localparam logic [3:0] TAG_RSIZE  = 4'd7;
  localparam logic [3:0] TAG_RID    = 4'd8;
  localparam logic [3:0] TAG_RCOUNT = 4'd9;
  localparam logic [3:0] TAG_PUSH   = 4'd10;
  localparam logic [3:0] TAG_POP    = 4'd11;

  localparam logic [3:0] TAG_USAGE  = 4'd0;
  localparam logic [3:0] TAG_UMIN   = 4'd1;
  localparam logic [3:0] TAG_UMAX   = 4'd2;

  localparam logic [3:0] TAG_INPUT      = 4'd8;
  localparam logic [3:0] TAG_OUTPUT     = 4'd9;
  localparam logic [3:0] TAG_COLLECTION = 4'd10;
  localparam logic [3:0] TAG_FEATURE    = 4'd11;
  localparam logic [3:0] TAG_END_COLL   = 4'd12;

  localparam int STACK_W = 152;

  function automatic logic [2:0] item_len(input logic [7:0] hdr);
    item_len = (hdr[1:0] == 2'd3) ? 3'd4 : {1'b0, hdr[1:0]};
  endfunction

endpackage

@@ design/hrdp_desc_if.sv @@
interface hrdp_desc_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       end_of_descriptor;

  modport source (output valid, desc_byte, end_of_descriptor, input ready);
  modport sink (input valid, desc_byte, end_of_descriptor, output ready);
endinterface

@@ design/hrdp_elem_if.sv @@
interface hrdp_elem_if;
  logic               valid;
  logic               ready;
  logic [5:0]         element_index;
  logic [7:0]         elem_report_id;
  logic [15:0]        elem_bit_pos;
  logic [15:0]        elem_bit_width;
  logic signed [31:0] logical_minimum;
  logic signed [31:0] logical_maximum;
  logic [15:0]        page_of_usage;
  logic [15:0]        usage_code;
  logic               relative_flag;
  logic               variable_flag;
  logic               signed_flag;
  logic               last_of_run;

  modport source (output valid, element_index, elem_report_id, elem_bit_pos, elem_bit_width,
    logical_minimum, logical_maximum, page_of_usage, usage_code, relative_flag,
    variable_flag, signed_flag, last_of_run, input ready);
  modport sink (input valid, element_index, elem_report_id, elem_bit_pos, elem_bit_width,
    logical_minimum, logical_maximum, page_of_usage, usage_code, relative_flag,
    variable_flag, signed_flag, last_of_run, output ready);
endinterface

@@ design/hrdp_ram.sv @@
module hrdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/hid_report_descriptor_parser.sv @@
// HID report descriptor parser.
// Descriptor bytes come in on desc_in, one per transfer; end_of_descriptor
// marks the final byte, after which all parser state returns to reset.
// Elements leave on elem_out, one per transfer, in descriptor order.
// A byte that does not finish an item is taken in S_IN. A finished global,
// local or non-input main item passes through S_EXEC and S_DONE; a Pop
// also passes through S_POP. An Input item passes through S_EXEC, S_OFF,
// S_OWR and S_DONE, with a usage list read in S_UREAD before each S_EMIT.
// The first element is loaded in S_EMIT, after S_EXEC, S_OFF and S_UREAD.
// Bytes are not taken while an item is being executed.
// A stalled receiver holds the element in the output register, and the
// parser waits with the next element until that transfer completes.
// Reset clears all state at once; per report ID offsets carry valid bits,
// so no clearing pass is needed. Stack and usage list live in memories.
`include "hid_report_descriptor_parser_macros.svh"
module hid_report_descriptor_parser #(
  parameter int USAGE_SLOTS     = 64,
  parameter int ELEMENT_LIMIT   = 64,
  parameter int STACK_DEPTH     = 4,
  parameter int REPORT_ID_SLOTS = 256
) (
  input logic         clk,
  input logic         rst,
  hrdp_desc_if.sink   desc_in,
  hrdp_elem_if.source elem_out
);
  localparam int UAW = USAGE_SLOTS > 1 ? $clog2(USAGE_SLOTS) : 1;
  localparam int UCW = $clog2(USAGE_SLOTS + 1);
  localparam int EW  = $clog2(ELEMENT_LIMIT + 1);
  localparam int SAW = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int RAW = REPORT_ID_SLOTS > 1 ? $clog2(REPORT_ID_SLOTS) : 1;

  hrdp_pkg::state_t state, state_next;

  logic [7:0]  item_header;
  logic [31:0] item_data;
  logic [2:0]  bytes_pending;
  logic [7:0]  x_hdr;
  logic [31:0] x_data;
  logic        last_q;

  logic [15:0] cur_usage_page;
  logic [31:0] cur_logical_min;
  logic [31:0] cur_logical_max;
  logic [31:0] cur_report_size;
  logic [31:0] cur_report_count;
  logic [7:0]  cur_report_id;
  logic [SLW-1:0] stack_level;
  logic [UCW-1:0] usage_fill;
  logic [15:0] range_min;
  logic [15:0] range_max;
  logic [EW-1:0] emitted;
  logic [REPORT_ID_SLOTS-1:0] offs_valid;
  logic        offs_valid_q;

  logic [15:0]   start;
  logic [15:0]   prod;
  logic [15:0]   acc;
  logic [EW-1:0] cnt;
  logic [EW-1:0] idx;
  logic          out_valid;

  function automatic logic [RAW-1:0] id_slot(input logic [7:0] id);
    logic [16:0] r;
    r = {9'd0, id};
    for (int b = 7; b >= 0; b--) begin
      if (r >= (17'(REPORT_ID_SLOTS) << b)) begin
        r = r - (17'(REPORT_ID_SLOTS) << b);
      end
    end
    return r[RAW-1:0];
  endfunction

  function automatic logic [31:0] widen(input logic [31:0] v, input logic [2:0] n);
    case (n)
      3'd1:    widen = {{24{v[7]}}, v[7:0]};
      3'd2:    widen = {{16{v[15]}}, v[15:0]};
      default: widen = v;
    endcase
  endfunction

  logic [1:0] x_type;
  logic [3:0] x_tag;
  assign x_type = x_hdr[3:2];
  assign x_tag  = x_hdr[7:4];

  logic [RAW-1:0] slot;
  assign slot = id_slot(cur_report_id);

  // Byte assembly.
  logic        in_xfer;
  logic [2:0]  hlen;
  logic [2:0]  pend_dec;
  logic [1:0]  pos;
  logic [31:0] data_acc;
  logic        run_item;
  logic [31:0] run_data;
  assign in_xfer  = desc_in.valid && desc_in.ready;
  assign hlen     = hrdp_pkg::item_len(item_header);
  assign pend_dec = bytes_pending - 3'd1;
  assign pos      = 2'(hlen - bytes_pending);
  assign data_acc = item_data | ({24'd0, desc_in.desc_byte} << {pos, 3'b000});

  always_comb begin
    if (bytes_pending == 3'd0) begin
      run_item = (hrdp_pkg::item_len(desc_in.desc_byte) == 3'd0) || desc_in.end_of_descriptor;
      run_data = 32'd0;
    end else begin
      run_item = (pend_dec == 3'd0) || desc_in.end_of_descriptor;
      run_data = (pend_dec == 3'd0) ? data_acc : 32'd0;
    end
  end

  // Memories.
  logic          st_we, st_re;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [hrdp_pkg::STACK_W-1:0] st_wdata, st_rdata;
  logic          us_we, us_re;
  logic [UAW-1:0] us_waddr, us_raddr;
  logic [15:0]   us_rdata;
  logic          of_we, of_re;
  logic [15:0]   of_wdata, of_rdata;

  hrdp_ram #(.WIDTH(hrdp_pkg::STACK_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata));
  hrdp_ram #(.WIDTH(16), .DEPTH(USAGE_SLOTS)) u_usage (
    .clk(clk), .we(us_we), .waddr(us_waddr), .wdata(x_data[15:0]),
    .re(us_re), .raddr(us_raddr), .rdata(us_rdata));
  hrdp_ram #(.WIDTH(16), .DEPTH(REPORT_ID_SLOTS)) u_offs (
    .clk(clk), .we(of_we), .waddr(slot), .wdata(of_wdata),
    .re(of_re), .raddr(slot), .rdata(of_rdata));

  logic is_push, is_pop, is_usage, is_input, is_main_clr;
  assign is_push  = (x_type == hrdp_pkg::TYPE_GLOBAL) && (x_tag == hrdp_pkg::TAG_PUSH)
                    && (stack_level < SLW'(STACK_DEPTH));
  assign is_pop   = (x_type == hrdp_pkg::TYPE_GLOBAL) && (x_tag == hrdp_pkg::TAG_POP)
                    && (stack_level != '0);
  assign is_usage = (x_type == hrdp_pkg::TYPE_LOCAL) && (x_tag == hrdp_pkg::TAG_USAGE)
                    && (usage_fill < UCW'(USAGE_SLOTS));
  assign is_input = (x_type == hrdp_pkg::TYPE_MAIN) && (x_tag == hrdp_pkg::TAG_INPUT);
  assign is_main_clr = (x_type == hrdp_pkg::TYPE_MAIN) && (x_tag inside
                       {hrdp_pkg::TAG_OUTPUT, hrdp_pkg::TAG_COLLECTION,
                        hrdp_pkg::TAG_FEATURE, hrdp_pkg::TAG_END_COLL});

  logic [UCW-1:0] ucm1;
  logic [UCW-1:0] idx_w;
  logic [UCW-1:0] kpick;
  assign ucm1  = usage_fill - UCW'(1);
  assign idx_w = (32'(idx) < 32'(ucm1)) ? UCW'(idx) : ucm1;
  assign kpick = idx_w;

  logic can_load;
  assign can_load = !out_valid || elem_out.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      hrdp_pkg::S_IN:    if (in_xfer && run_item) state_next = hrdp_pkg::S_EXEC;
      hrdp_pkg::S_EXEC: begin
        if (is_pop) state_next = hrdp_pkg::S_POP;
        else if (is_input) state_next = hrdp_pkg::S_OFF;
        else state_next = hrdp_pkg::S_DONE;
      end
      hrdp_pkg::S_POP:   state_next = hrdp_pkg::S_DONE;
      hrdp_pkg::S_OFF: begin
        if (x_data[0] || cur_report_count == 32'd0 || emitted == EW'(ELEMENT_LIMIT)) begin
          state_next = hrdp_pkg::S_OWR;
        end else begin
          state_next = hrdp_pkg::S_UREAD;
        end
      end
      hrdp_pkg::S_UREAD: state_next = hrdp_pkg::S_EMIT;
      hrdp_pkg::S_EMIT: begin
        if (can_load) begin
          state_next = (idx + EW'(1) == cnt) ? hrdp_pkg::S_OWR : hrdp_pkg::S_UREAD;
        end
      end
      hrdp_pkg::S_OWR:   state_next = hrdp_pkg::S_DONE;
      hrdp_pkg::S_DONE:  state_next = hrdp_pkg::S_IN;
      default:           state_next = hrdp_pkg::S_IN;
    endcase
  end

  // Memory control and handshake.
  always_comb begin
    desc_in.ready = (state == hrdp_pkg::S_IN);
    st_we    = (state == hrdp_pkg::S_EXEC) && is_push;
    st_waddr = SAW'(stack_level);
    st_wdata = {cur_usage_page, cur_report_id, cur_logical_min, cur_logical_max,
                cur_report_size, cur_report_count};
    st_re    = (state == hrdp_pkg::S_EXEC) && is_pop;
    st_raddr = SAW'(stack_level - SLW'(1));
    us_we    = (state == hrdp_pkg::S_EXEC) && is_usage;
    us_waddr = UAW'(usage_fill);
    us_re    = (state == hrdp_pkg::S_UREAD);
    us_raddr = UAW'(kpick);
    of_re    = (state == hrdp_pkg::S_EXEC) && is_input;
    of_we    = (state == hrdp_pkg::S_OWR);
    of_wdata = start + prod;
  end

  logic [EW-1:0] room;
  logic [EW-1:0] cnt_calc;
  assign room     = EW'(ELEMENT_LIMIT) - emitted;
  assign cnt_calc = (cur_report_count < 32'(room)) ? EW'(cur_report_count) : room;

  logic [16:0] rsum;
  logic [15:0] usage_pick;
  assign rsum = {1'b0, range_min} + 17'(idx);
  always_comb begin
    if (usage_fill != '0) begin
      usage_pick = us_rdata;
    end else if (range_max != 16'd0) begin
      if (range_min >= range_max) usage_pick = range_min;
      else usage_pick = (rsum < {1'b0, range_max}) ? rsum[15:0] : range_max;
    end else begin
      usage_pick = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrdp_pkg::S_IN;
      item_header <= '0;
      item_data <= '0;
      bytes_pending <= '0;
      last_q <= 1'b0;
      cur_usage_page <= '0;
      cur_logical_min <= '0;
      cur_logical_max <= '0;
      cur_report_size <= '0;
      cur_report_count <= '0;
      cur_report_id <= '0;
      stack_level <= '0;
      usage_fill <= '0;
      range_min <= '0;
      range_max <= '0;
      emitted <= '0;
      offs_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hrdp_pkg::S_EMIT && can_load) begin
        out_valid <= 1'b1;
      end else if (elem_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        hrdp_pkg::S_IN: begin
          if (in_xfer) begin
            last_q <= desc_in.end_of_descriptor;
            x_data <= run_data;
            if (bytes_pending == 3'd0) begin
              item_header <= desc_in.desc_byte;
              item_data <= '0;
              bytes_pending <= hrdp_pkg::item_len(desc_in.desc_byte);
              x_hdr <= desc_in.desc_byte;
            end else begin
              item_data <= data_acc;
              bytes_pending <= pend_dec;
              x_hdr <= item_header;
            end
          end
        end
        hrdp_pkg::S_EXEC: begin
          if (x_type == hrdp_pkg::TYPE_GLOBAL) begin
            case (x_tag)
              hrdp_pkg::TAG_PAGE:   cur_usage_page <= x_data[15:0];
              hrdp_pkg::TAG_LMIN:   cur_logical_min <= widen(x_data,
                                      hrdp_pkg::item_len(x_hdr));
              hrdp_pkg::TAG_LMAX:   cur_logical_max <= widen(x_data,
                                      hrdp_pkg::item_len(x_hdr));
              hrdp_pkg::TAG_RSIZE:  cur_report_size <= x_data;
              hrdp_pkg::TAG_RID:    cur_report_id <= x_data[7:0];
              hrdp_pkg::TAG_RCOUNT: cur_report_count <= x_data;
              hrdp_pkg::TAG_PUSH:   if (is_push) stack_level <= stack_level + SLW'(1);
              default: ;
            endcase
          end else if (x_type == hrdp_pkg::TYPE_LOCAL) begin
            case (x_tag)
              hrdp_pkg::TAG_USAGE: if (is_usage) usage_fill <= usage_fill + UCW'(1);
              hrdp_pkg::TAG_UMIN:  range_min <= x_data[15:0];
              hrdp_pkg::TAG_UMAX:  range_max <= x_data[15:0];
              default: ;
            endcase
          end else if (is_main_clr) begin
            usage_fill <= '0;
            range_min <= '0;
            range_max <= '0;
          end
          offs_valid_q <= offs_valid[slot];
        end
        hrdp_pkg::S_POP: begin
          stack_level <= stack_level - SLW'(1);
          {cur_usage_page, cur_report_id, cur_logical_min, cur_logical_max,
           cur_report_size, cur_report_count} <= st_rdata;
        end
        hrdp_pkg::S_OFF: begin
          start <= offs_valid_q ? of_rdata : 16'd0;
          acc   <= offs_valid_q ? of_rdata : 16'd0;
          prod  <= 16'(cur_report_size[15:0] * cur_report_count[15:0]);
          cnt   <= cnt_calc;
          idx   <= '0;
        end
        hrdp_pkg::S_EMIT: begin
          if (can_load) begin
            elem_out.element_index   <= 6'(emitted);
            elem_out.elem_report_id  <= cur_report_id;
            elem_out.elem_bit_pos    <= acc;
            elem_out.elem_bit_width  <= cur_report_size[15:0];
            elem_out.logical_minimum <= cur_logical_min;
            elem_out.logical_maximum <= cur_logical_max;
            elem_out.page_of_usage   <= cur_usage_page;
            elem_out.usage_code      <= usage_pick;
            elem_out.relative_flag   <= x_data[2];
            elem_out.variable_flag   <= x_data[1];
            elem_out.signed_flag     <= cur_logical_min[31];
            elem_out.last_of_run     <= (idx + EW'(1) == cnt);
            acc <= acc + cur_report_size[15:0];
            idx <= idx + EW'(1);
            emitted <= emitted + EW'(1);
          end
        end
        hrdp_pkg::S_OWR: begin
          offs_valid[slot] <= 1'b1;
          usage_fill <= '0;
          range_min <= '0;
          range_max <= '0;
        end
        hrdp_pkg::S_DONE: begin
          if (last_q) begin
            item_header <= '0;
            item_data <= '0;
            bytes_pending <= '0;
            cur_usage_page <= '0;
            cur_logical_min <= '0;
            cur_logical_max <= '0;
            cur_report_size <= '0;
            cur_report_count <= '0;
            cur_report_id <= '0;
            stack_level <= '0;
            usage_fill <= '0;
            range_min <= '0;
            range_max <= '0;
            emitted <= '0;
            offs_valid <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign elem_out.valid = out_valid;

  `ASSERT_ALWAYS(a_emit_limit, clk, rst, emitted <= EW'(ELEMENT_LIMIT))
  `ASSERT_ALWAYS(a_stack_bound, clk, rst, stack_level <= SLW'(STACK_DEPTH))
  `ASSERT_IMPLIES(a_idx_in_run, clk, rst, state == hrdp_pkg::S_EMIT, idx < cnt)
  `ASSERT_NEXT(a_no_byte_busy, clk, rst, in_xfer && run_item, !desc_in.ready)
endmodule
